// ===== src/rp66vd_pkg.sv =====
// ----------------------------------------------------------------------------
// RP66 v1 value decoder package
// Payload types, representation codes, result part and status codes, and the
// fixed-length table for the value decoder.
// ----------------------------------------------------------------------------
package rp66vd_pkg;

   // Default upper bound on the length of a string value.
   localparam int DEFAULT_MAX_STRING_BYTES = 4096;

   // Representation codes handled by name.
   localparam logic [4:0] RC_FSINGL    = 5'd2;
   localparam logic [4:0] RC_FDOUBL    = 5'd7;
   localparam logic [4:0] RC_SSHORT    = 5'd12;
   localparam logic [4:0] RC_SNORM     = 5'd13;
   localparam logic [4:0] RC_SLONG     = 5'd14;
   localparam logic [4:0] RC_USHORT    = 5'd15;
   localparam logic [4:0] RC_UNORM     = 5'd16;
   localparam logic [4:0] RC_ULONG     = 5'd17;
   localparam logic [4:0] RC_UVARI     = 5'd18;
   localparam logic [4:0] RC_IDENT     = 5'd19;
   localparam logic [4:0] RC_ASCII     = 5'd20;
   localparam logic [4:0] RC_DTIME     = 5'd21;
   localparam logic [4:0] RC_ORIGIN    = 5'd22;
   localparam logic [4:0] RC_OBNAME    = 5'd23;
   localparam logic [4:0] RC_OBJREF    = 5'd24;
   localparam logic [4:0] RC_ATTREF    = 5'd25;
   localparam logic [4:0] RC_STATUS    = 5'd26;
   localparam logic [4:0] RC_UNITS     = 5'd27;
   localparam logic [4:0] RC_NONE      = 5'd0;
   localparam logic [4:0] RC_LAST_CODE = 5'd27;

   // Result part codes.
   localparam logic [3:0] PART_INTEGER  = 4'd0;
   localparam logic [3:0] PART_FLOAT32  = 4'd1;
   localparam logic [3:0] PART_FLOAT64  = 4'd2;
   localparam logic [3:0] PART_DTIME    = 4'd3;
   localparam logic [3:0] PART_STR_LEN  = 4'd4;
   localparam logic [3:0] PART_STR_BYTE = 4'd5;
   localparam logic [3:0] PART_ORIGIN   = 4'd6;
   localparam logic [3:0] PART_COPY     = 4'd7;
   localparam logic [3:0] PART_NAME_LEN = 4'd8;
   localparam logic [3:0] PART_NAME_BYTE = 4'd9;
   localparam logic [3:0] PART_TYPE_LEN = 4'd10;
   localparam logic [3:0] PART_TYPE_BYTE = 4'd11;

   // Result status codes.
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TRUNCATED   = 3'd1;
   localparam logic [2:0] ST_BAD_CODE    = 3'd2;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
   localparam logic [2:0] ST_TOO_LONG    = 3'd4;

   // Offsets removed from two- and four-byte variable-length integers.
   localparam logic [31:0] VARI_SHORT_BASE = 32'h0000_8000;
   localparam logic [31:0] VARI_LONG_BASE  = 32'hC000_0000;

   // Input transaction: one byte of the value stream.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
      logic [4:0] rep_code;
      logic       end_of_data;
   } req_type;

   // Result transaction: one decoded component.
   typedef struct packed {
      logic [3:0]  part;
      logic [63:0] value_word;
      logic        last;
      logic [2:0]  status;
      logic [15:0] byte_count;
   } rsp_type;

   // Byte length of each fixed-size code; zero for variable-length codes.
   function automatic logic [4:0] fixed_len(input logic [4:0] code);
      logic [4:0] len;
      unique case (code)
         5'd1:    len = 5'd2;
         5'd2:    len = 5'd4;
         5'd3:    len = 5'd8;
         5'd4:    len = 5'd12;
         5'd5:    len = 5'd4;
         5'd6:    len = 5'd4;
         5'd7:    len = 5'd8;
         5'd8:    len = 5'd16;
         5'd9:    len = 5'd24;
         5'd10:   len = 5'd8;
         5'd11:   len = 5'd16;
         5'd12:   len = 5'd1;
         5'd13:   len = 5'd2;
         5'd14:   len = 5'd4;
         5'd15:   len = 5'd1;
         5'd16:   len = 5'd2;
         5'd17:   len = 5'd4;
         5'd21:   len = 5'd8;
         5'd26:   len = 5'd1;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== src/rp66vd_parser.sv =====
// ----------------------------------------------------------------------------
// RP66 v1 value parser
// Holds the parse state and decodes one accepted byte per cycle into at most
// one result, which the top level registers.
// ----------------------------------------------------------------------------
module rp66vd_parser
   import rp66vd_pkg::*;
#(
   parameter int MAX_STRING_BYTES = DEFAULT_MAX_STRING_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    res_valid,
   output rsp_type res
);

   localparam int LW = $clog2(MAX_STRING_BYTES + 1);

   typedef enum logic [9:0] {
      PH_IDLE         = 10'b00_0000_0001,
      PH_FIRST        = 10'b00_0000_0010,
      PH_FIXED        = 10'b00_0000_0100,
      PH_VARI         = 10'b00_0000_1000,
      PH_COPY         = 10'b00_0001_0000,
      PH_NAMELEN      = 10'b00_0010_0000,
      PH_NAMEBYTES    = 10'b00_0100_0000,
      PH_STRBYTES     = 10'b00_1000_0000,
      PH_TYPEBYTES    = 10'b01_0000_0000,
      PH_ORIGIN_START = 10'b10_0000_0000
   } phase_type;

   phase_type     phase_ff, phase_in, cur_phase;
   logic [4:0]    code_ff, code_in, cur_code;
   logic [63:0]   acc_ff, acc_in;
   logic [LW-1:0] left_ff, left_in;
   logic [15:0]   vb_ff, vb_in;

   logic [7:0]    b;
   logic [4:0]    fl;
   logic [31:0]   vari_word, vari_val, vv, str_len;
   logic [63:0]   fix_word;
   logic          start_done, vf, vari_done, fix_done, str_start;

   assign b = req.data_byte;

   // Next parse state and result for the byte on the input.
   always_comb begin
      phase_in   = phase_ff;
      code_in    = code_ff;
      acc_in     = acc_ff;
      left_in    = left_ff;
      vb_in      = vb_ff;
      res_valid  = 1'b0;
      res        = '0;
      cur_phase  = phase_ff;
      cur_code   = code_ff;
      start_done = 1'b0;
      vf         = 1'b0;
      vari_done  = 1'b0;
      fix_done   = 1'b0;
      str_start  = 1'b0;
      vv         = '0;
      str_len    = '0;
      fix_word   = {acc_ff[55:0], b};
      vari_word  = {acc_ff[23:0], b};
      vari_val   = (vari_word >= VARI_LONG_BASE) ? vari_word - VARI_LONG_BASE
                                                 : vari_word - VARI_SHORT_BASE;

      // A start byte opens a new value, or is answered at once.
      if (req.start_req) begin
         code_in  = req.rep_code;
         cur_code = req.rep_code;
         vb_in    = '0;
         acc_in   = '0;
         left_in  = '0;
         if (req.rep_code == RC_NONE || req.rep_code > RC_LAST_CODE) begin
            res_valid      = 1'b1;
            res.last       = 1'b1;
            res.status     = ST_BAD_CODE;
            vb_in          = 16'd1;
            res.byte_count = 16'd1;
            phase_in       = PH_IDLE;
            cur_phase      = PH_IDLE;
            start_done     = 1'b1;
         end else if (req.rep_code == RC_ATTREF) begin
            res_valid  = 1'b1;
            res.last   = 1'b1;
            res.status = ST_UNSUPPORTED;
            phase_in   = PH_IDLE;
            cur_phase  = PH_IDLE;
            start_done = 1'b1;
         end else begin
            phase_in  = PH_FIRST;
            cur_phase = PH_FIRST;
         end
      end

      fl = fixed_len(cur_code);

      if (!start_done && cur_phase != PH_IDLE) begin
         // Byte handling by phase.
         unique case (cur_phase)
            PH_FIRST: begin
               if (fl != 5'd0) begin
                  fix_word = {56'd0, b};
                  acc_in   = fix_word;
                  left_in  = LW'(fl) - LW'(1);
                  phase_in = PH_FIXED;
                  fix_done = (fl == 5'd1);
               end else if (cur_code == RC_IDENT || cur_code == RC_UNITS) begin
                  str_start = 1'b1;
                  str_len   = {24'd0, b};
               end else if (cur_code == RC_OBJREF) begin
                  res_valid      = 1'b1;
                  res.part       = PART_TYPE_LEN;
                  res.value_word = {56'd0, b};
                  if (b == 8'd0) begin
                     phase_in = PH_ORIGIN_START;
                  end else begin
                     left_in  = LW'(b);
                     phase_in = PH_TYPEBYTES;
                  end
               end else begin
                  vf = 1'b1;
               end
            end
            PH_FIXED: begin
               acc_in   = fix_word;
               left_in  = left_ff - LW'(1);
               fix_done = (left_ff == LW'(1));
            end
            PH_VARI: begin
               acc_in  = {32'd0, vari_word};
               left_in = left_ff - LW'(1);
               if (left_ff == LW'(1)) begin
                  vari_done = 1'b1;
                  vv        = vari_val;
               end
            end
            PH_ORIGIN_START: begin
               vf = 1'b1;
            end
            PH_COPY: begin
               res_valid      = 1'b1;
               res.part       = PART_COPY;
               res.value_word = {56'd0, b};
               phase_in       = PH_NAMELEN;
            end
            PH_NAMELEN: begin
               res_valid      = 1'b1;
               res.part       = PART_NAME_LEN;
               res.value_word = {56'd0, b};
               if (b == 8'd0) begin
                  res.last = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  left_in  = LW'(b);
                  phase_in = PH_NAMEBYTES;
               end
            end
            PH_NAMEBYTES, PH_STRBYTES: begin
               res_valid      = 1'b1;
               res.part       = (cur_phase == PH_NAMEBYTES) ? PART_NAME_BYTE
                                                            : PART_STR_BYTE;
               res.value_word = {56'd0, b};
               res.last       = (left_ff == LW'(1));
               left_in        = left_ff - LW'(1);
               if (left_ff == LW'(1)) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_TYPEBYTES: begin
               res_valid      = 1'b1;
               res.part       = PART_TYPE_BYTE;
               res.value_word = {56'd0, b};
               left_in        = left_ff - LW'(1);
               if (left_ff == LW'(1)) begin
                  phase_in = PH_ORIGIN_START;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // First byte of a variable-length integer picks its size.
         if (vf) begin
            if (!b[7]) begin
               vari_done = 1'b1;
               vv        = {24'd0, b};
            end else begin
               acc_in   = {56'd0, b};
               left_in  = b[6] ? LW'(3) : LW'(1);
               phase_in = PH_VARI;
            end
         end

         // Completed fixed-size value.
         if (fix_done) begin
            res_valid = 1'b1;
            res.last  = 1'b1;
            phase_in  = PH_IDLE;
            case (cur_code)
               RC_FSINGL: begin
                  res.part       = PART_FLOAT32;
                  res.value_word = {32'd0, fix_word[31:0]};
               end
               RC_FDOUBL: begin
                  res.part       = PART_FLOAT64;
                  res.value_word = fix_word;
               end
               RC_DTIME: begin
                  res.part       = PART_DTIME;
                  res.value_word = fix_word;
               end
               RC_SSHORT: res.value_word = {{56{fix_word[7]}}, fix_word[7:0]};
               RC_SNORM:  res.value_word = {{48{fix_word[15]}}, fix_word[15:0]};
               RC_SLONG:  res.value_word = {{32{fix_word[31]}}, fix_word[31:0]};
               RC_USHORT, RC_STATUS: res.value_word = {56'd0, fix_word[7:0]};
               RC_UNORM:  res.value_word = {48'd0, fix_word[15:0]};
               RC_ULONG:  res.value_word = {32'd0, fix_word[31:0]};
               default:   res.status     = ST_UNSUPPORTED;
            endcase
         end

         // Completed variable-length integer.
         if (vari_done) begin
            case (cur_code)
               RC_UVARI: begin
                  res_valid      = 1'b1;
                  res.value_word = {32'd0, vv};
                  res.last       = 1'b1;
                  phase_in       = PH_IDLE;
               end
               RC_ORIGIN: begin
                  res_valid      = 1'b1;
                  res.part       = PART_ORIGIN;
                  res.value_word = {32'd0, vv};
                  res.last       = 1'b1;
                  phase_in       = PH_IDLE;
               end
               RC_ASCII: begin
                  str_start = 1'b1;
                  str_len   = vv;
               end
               default: begin
                  res_valid      = 1'b1;
                  res.part       = PART_ORIGIN;
                  res.value_word = {32'd0, vv};
                  phase_in       = PH_COPY;
               end
            endcase
         end

         // String length: reject, close or start the byte run.
         if (str_start) begin
            res_valid      = 1'b1;
            res.part       = PART_STR_LEN;
            res.value_word = {32'd0, str_len};
            if (str_len > 32'(MAX_STRING_BYTES)) begin
               res.last   = 1'b1;
               res.status = ST_TOO_LONG;
               phase_in   = PH_IDLE;
            end else if (str_len == 32'd0) begin
               res.last = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               left_in  = str_len[LW-1:0];
               phase_in = PH_STRBYTES;
            end
         end

         // Saturating count of bytes taken by this value.
         if (vb_in != 16'hFFFF) begin
            vb_in = vb_in + 16'd1;
         end

         // The buffer ends before the value does.
         if (phase_in != PH_IDLE && req.end_of_data) begin
            if (!res_valid) begin
               res_valid = 1'b1;
               unique case (phase_in)
                  PH_FIXED: begin
                     if (cur_code == RC_FSINGL) begin
                        res.part = PART_FLOAT32;
                     end else if (cur_code == RC_FDOUBL) begin
                        res.part = PART_FLOAT64;
                     end else if (cur_code == RC_DTIME) begin
                        res.part = PART_DTIME;
                     end else begin
                        res.part = PART_INTEGER;
                     end
                  end
                  PH_VARI: begin
                     if (cur_code == RC_ASCII) begin
                        res.part = PART_STR_LEN;
                     end else if (cur_code == RC_UVARI) begin
                        res.part = PART_INTEGER;
                     end else begin
                        res.part = PART_ORIGIN;
                     end
                  end
                  PH_ORIGIN_START: res.part = PART_ORIGIN;
                  PH_COPY:         res.part = PART_COPY;
                  PH_NAMELEN:      res.part = PART_NAME_LEN;
                  PH_NAMEBYTES:    res.part = PART_NAME_BYTE;
                  PH_STRBYTES:     res.part = PART_STR_BYTE;
                  PH_TYPEBYTES:    res.part = PART_TYPE_BYTE;
                  default:         res.part = PART_INTEGER;
               endcase
            end
            res.last   = 1'b1;
            res.status = ST_TRUNCATED;
            phase_in   = PH_IDLE;
         end

         res.byte_count = res.last ? vb_in : 16'd0;
      end
   end

   // Parse state advances on every accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         code_ff  <= '0;
         acc_ff   <= '0;
         left_ff  <= '0;
         vb_ff    <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         code_ff  <= code_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         vb_ff    <= vb_in;
      end
   end

endmodule

// ===== src/rp66_value_decoder_core.sv =====
// ----------------------------------------------------------------------------
// RP66 v1 value decoder core
// Decodes a byte stream of RP66 v1 values into integers, raw float and time
// bits, strings and object-name components, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one stream byte per transaction, with a start
//   flag and representation code on the first byte of each value and an
//   end-of-data flag on the last byte available. The rsp channel carries the
//   decoded components, at most one per input byte, with last and the byte
//   count on the final component of a value and a status code.
//   A result appears on rsp the cycle after the byte that caused it is
//   accepted. Throughput is one byte per cycle unless a held result
//   stalls the input, set by the single pass through the parser between
//   the input and the result register. Bytes that produce no result
//   never occupy the output. When the receiver stalls with a result held,
//   req_ready stays high only while that result is being taken in the same
//   cycle; otherwise input is held off until the output register drains.
//   Reset returns the parser to idle, awaiting a start byte, and empties the
//   result register.
// ----------------------------------------------------------------------------
module rp66_value_decoder_core
   import rp66vd_pkg::*;
#(
   parameter int MAX_STRING_BYTES = DEFAULT_MAX_STRING_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    accept;
   logic    res_valid;
   rsp_type res;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // Take a byte whenever the output register is empty or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   rp66vd_parser #(
      .MAX_STRING_BYTES (MAX_STRING_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output register occupancy.
   assign rsp_valid_in = accept ? res_valid : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload is loaded only with a new result.
   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== test/rp66vd_value_checker.sv =====
// ----------------------------------------------------------------------------
// RP66 v1 value decoder checker
// Watches both channels of the value decoder. Every accepted input
// transaction is run through an independent decoder of its own, and every
// decoded component it produces is queued. Each accepted result transaction
// is compared field by field with the oldest queued component. The number of
// failures and of components still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module rp66vd_value_checker
   import rp66vd_pkg::*;
#(
   parameter int MAX_STRING_BYTES = DEFAULT_MAX_STRING_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   // Fixed-size codes that are not decoded: their bytes are taken and reported as unsupported.
   localparam logic [4:0] RC_FSHORT = 5'd1;
   localparam logic [4:0] RC_FSING1 = 5'd3;
   localparam logic [4:0] RC_FSING2 = 5'd4;
   localparam logic [4:0] RC_ISINGL = 5'd5;
   localparam logic [4:0] RC_VSINGL = 5'd6;
   localparam logic [4:0] RC_FDOUB1 = 5'd8;
   localparam logic [4:0] RC_FDOUB2 = 5'd9;
   localparam logic [4:0] RC_CSINGL = 5'd10;
   localparam logic [4:0] RC_CDOUBL = 5'd11;

   typedef enum logic [3:0] {
      PS_IDLE,
      PS_FIRST,
      PS_FIXED,
      PS_VARI,
      PS_COPY,
      PS_NAME_LEN,
      PS_NAME_BYTES,
      PS_STR_BYTES,
      PS_TYPE_BYTES,
      PS_ORIGIN
   } parse_state_type;

   // State of the decoder under prediction.
   parse_state_type parse_state = PS_IDLE;
   logic [4:0]      value_code  = RC_NONE;
   logic [63:0]     acc         = '0;
   logic [31:0]     bytes_left  = '0;
   logic [15:0]     value_len   = '0;

   // Component produced by the current byte, if any.
   logic    have_part;
   rsp_type part_out;

   rsp_type expected_parts[$];
   int      errors = 0;

   function automatic logic [4:0] fixed_size(input logic [4:0] code);
      case (code)
         RC_SSHORT, RC_USHORT, RC_STATUS:                     return 5'd1;
         RC_FSHORT, RC_SNORM, RC_UNORM:                       return 5'd2;
         RC_FSINGL, RC_ISINGL, RC_VSINGL, RC_SLONG, RC_ULONG: return 5'd4;
         RC_FSING1, RC_FDOUBL, RC_CSINGL, RC_DTIME:           return 5'd8;
         RC_FSING2:                                           return 5'd12;
         RC_FDOUB1, RC_CDOUBL:                                return 5'd16;
         RC_FDOUB2:                                           return 5'd24;
         default:                                             return 5'd0;
      endcase
   endfunction

   function automatic void emit_part(input logic [3:0] part, input logic [63:0] word,
                                     input logic last, input logic [2:0] status);
      have_part           = 1'b1;
      part_out.part       = part;
      part_out.value_word = word;
      part_out.last       = last;
      part_out.status     = status;
      part_out.byte_count = '0;
   endfunction

   // All bytes of a fixed-size value are in: extend and emit it.
   function automatic void finish_fixed();
      case (value_code)
         RC_FSINGL: emit_part(PART_FLOAT32, {32'b0, acc[31:0]}, 1'b1, ST_OK);
         RC_FDOUBL: emit_part(PART_FLOAT64, acc, 1'b1, ST_OK);
         RC_DTIME:  emit_part(PART_DTIME, acc, 1'b1, ST_OK);
         RC_SSHORT: emit_part(PART_INTEGER, {{56{acc[7]}}, acc[7:0]}, 1'b1, ST_OK);
         RC_SNORM:  emit_part(PART_INTEGER, {{48{acc[15]}}, acc[15:0]}, 1'b1, ST_OK);
         RC_SLONG:  emit_part(PART_INTEGER, {{32{acc[31]}}, acc[31:0]}, 1'b1, ST_OK);
         RC_USHORT, RC_STATUS:
            emit_part(PART_INTEGER, {56'b0, acc[7:0]}, 1'b1, ST_OK);
         RC_UNORM:  emit_part(PART_INTEGER, {48'b0, acc[15:0]}, 1'b1, ST_OK);
         RC_ULONG:  emit_part(PART_INTEGER, {32'b0, acc[31:0]}, 1'b1, ST_OK);
         default:   emit_part(PART_INTEGER, '0, 1'b1, ST_UNSUPPORTED);
      endcase
      parse_state = PS_IDLE;
   endfunction

   function automatic void open_string(input logic [31:0] len);
      if (len > 32'(MAX_STRING_BYTES)) begin
         emit_part(PART_STR_LEN, {32'b0, len}, 1'b1, ST_TOO_LONG);
         parse_state = PS_IDLE;
      end else if (len == 0) begin
         emit_part(PART_STR_LEN, '0, 1'b1, ST_OK);
         parse_state = PS_IDLE;
      end else begin
         emit_part(PART_STR_LEN, {32'b0, len}, 1'b0, ST_OK);
         bytes_left  = len;
         parse_state = PS_STR_BYTES;
      end
   endfunction

   // A variable-length integer is complete; what follows depends on the code.
   function automatic void vari_done(input logic [31:0] v);
      case (value_code)
         RC_UVARI: begin
            emit_part(PART_INTEGER, {32'b0, v}, 1'b1, ST_OK);
            parse_state = PS_IDLE;
         end
         RC_ORIGIN: begin
            emit_part(PART_ORIGIN, {32'b0, v}, 1'b1, ST_OK);
            parse_state = PS_IDLE;
         end
         RC_ASCII: open_string(v);
         default: begin
            emit_part(PART_ORIGIN, {32'b0, v}, 1'b0, ST_OK);
            parse_state = PS_COPY;
         end
      endcase
   endfunction

   function automatic void vari_head(input logic [7:0] b);
      if (!b[7]) begin
         vari_done({24'b0, b});
      end else begin
         acc         = {56'b0, b};
         bytes_left  = b[6] ? 32'd3 : 32'd1;
         parse_state = PS_VARI;
      end
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      logic [31:0] word;
      logic [3:0]  part;
      case (parse_state)
         PS_FIRST: begin
            if (fixed_size(value_code) != 0) begin
               acc         = {56'b0, b};
               bytes_left  = 32'(fixed_size(value_code)) - 1;
               parse_state = PS_FIXED;
               if (bytes_left == 0) finish_fixed();
            end else if (value_code == RC_IDENT || value_code == RC_UNITS) begin
               open_string({24'b0, b});
            end else if (value_code == RC_OBJREF) begin
               emit_part(PART_TYPE_LEN, {56'b0, b}, 1'b0, ST_OK);
               if (b == 0) begin
                  parse_state = PS_ORIGIN;
               end else begin
                  bytes_left  = {24'b0, b};
                  parse_state = PS_TYPE_BYTES;
               end
            end else begin
               vari_head(b);
            end
         end
         PS_FIXED: begin
            acc = {acc[55:0], b};
            bytes_left--;
            if (bytes_left == 0) finish_fixed();
         end
         PS_VARI: begin
            acc = {32'b0, acc[23:0], b};
            bytes_left--;
            if (bytes_left == 0) begin
               word = acc[31:0];
               vari_done(word >= VARI_LONG_BASE ? word - VARI_LONG_BASE
                                                : word - VARI_SHORT_BASE);
            end
         end
         PS_ORIGIN: vari_head(b);
         PS_COPY: begin
            emit_part(PART_COPY, {56'b0, b}, 1'b0, ST_OK);
            parse_state = PS_NAME_LEN;
         end
         PS_NAME_LEN: begin
            if (b == 0) begin
               emit_part(PART_NAME_LEN, '0, 1'b1, ST_OK);
               parse_state = PS_IDLE;
            end else begin
               emit_part(PART_NAME_LEN, {56'b0, b}, 1'b0, ST_OK);
               bytes_left  = {24'b0, b};
               parse_state = PS_NAME_BYTES;
            end
         end
         PS_NAME_BYTES, PS_STR_BYTES: begin
            part = (parse_state == PS_NAME_BYTES) ? PART_NAME_BYTE : PART_STR_BYTE;
            bytes_left--;
            emit_part(part, {56'b0, b}, bytes_left == 0, ST_OK);
            if (bytes_left == 0) parse_state = PS_IDLE;
         end
         PS_TYPE_BYTES: begin
            emit_part(PART_TYPE_BYTE, {56'b0, b}, 1'b0, ST_OK);
            bytes_left--;
            if (bytes_left == 0) parse_state = PS_ORIGIN;
         end
         default: ;
      endcase
   endfunction

   // Part that a truncated value reports when its last byte made no result.
   function automatic logic [3:0] open_part();
      case (parse_state)
         PS_FIXED:
            return value_code == RC_FSINGL ? PART_FLOAT32 :
                   value_code == RC_FDOUBL ? PART_FLOAT64 :
                   value_code == RC_DTIME  ? PART_DTIME   : PART_INTEGER;
         PS_VARI:
            return value_code == RC_ASCII ? PART_STR_LEN :
                   value_code == RC_UVARI ? PART_INTEGER : PART_ORIGIN;
         PS_ORIGIN:     return PART_ORIGIN;
         PS_COPY:       return PART_COPY;
         PS_NAME_LEN:   return PART_NAME_LEN;
         PS_NAME_BYTES: return PART_NAME_BYTE;
         PS_STR_BYTES:  return PART_STR_BYTE;
         PS_TYPE_BYTES: return PART_TYPE_BYTE;
         default:       return PART_INTEGER;
      endcase
   endfunction

   // Advance the decoder by one input transaction and queue what it yields.
   function automatic void decode_byte(input req_type t);
      have_part = 1'b0;
      if (t.start_req) begin
         value_code = t.rep_code;
         value_len  = '0;
         acc        = '0;
         bytes_left = '0;
         if (t.rep_code == RC_NONE || t.rep_code > RC_LAST_CODE) begin
            emit_part(PART_INTEGER, '0, 1'b1, ST_BAD_CODE);
            value_len   = 16'd1;
            parse_state = PS_IDLE;
         end else if (t.rep_code == RC_ATTREF) begin
            emit_part(PART_INTEGER, '0, 1'b1, ST_UNSUPPORTED);
            parse_state = PS_IDLE;
         end else begin
            parse_state = PS_FIRST;
         end
      end
      if (!have_part) begin
         if (parse_state == PS_IDLE) return;
         take_byte(t.data_byte);
         if (value_len != 16'hFFFF) value_len++;
         if (parse_state != PS_IDLE && t.end_of_data) begin
            if (!have_part) emit_part(open_part(), '0, 1'b1, ST_TRUNCATED);
            part_out.last   = 1'b1;
            part_out.status = ST_TRUNCATED;
            parse_state     = PS_IDLE;
         end
         if (!have_part) return;
      end
      part_out.byte_count = part_out.last ? value_len : '0;
      expected_parts.push_back(part_out);
   endfunction

   function automatic void check_field(input string field, input logic [63:0] want_v,
                                       input logic [63:0] got_v);
      if (want_v !== got_v) begin
         $display("%t: %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
         errors++;
      end
   endfunction

   // Predict on accepted input transactions, compare accepted results.
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         parse_state = PS_IDLE;
         value_code  = RC_NONE;
         acc         = '0;
         bytes_left  = '0;
         value_len   = '0;
         expected_parts.delete();
      end else begin
         if (req_valid && req_ready) decode_byte(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (expected_parts.size() == 0) begin
               $display("%t: result with nothing expected: actual %h", $time, rsp_payload);
               errors++;
            end else begin
               want = expected_parts.pop_front();
               check_field("part", 64'(want.part), 64'(rsp_payload.part));
               check_field("value_word", want.value_word, rsp_payload.value_word);
               check_field("last", 64'(want.last), 64'(rsp_payload.last));
               check_field("status", 64'(want.status), 64'(rsp_payload.status));
               check_field("byte_count", 64'(want.byte_count), 64'(rsp_payload.byte_count));
            end
         end
      end
      results_owed <= expected_parts.size();
      fail_count   <= errors;
   end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// RP66 v1 value decoder testbench
// Drives byte streams of RP66 v1 values into the decoder: a short directed
// run over the boundary cases, then random values of every code, mostly
// well formed, some truncated, restarted or mixed with stray bytes. Four
// phases vary sender gaps and receiver stalls. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import rp66vd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD   = 12;
   localparam int RESET_CYCLES   = 5;
   localparam int STRING_LIMIT   = DEFAULT_MAX_STRING_BYTES;
   localparam int PHASE_ITEMS    = 100;
   localparam int CODE_SPACE     = 32;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int REQ_BITS       = $bits(req_type);

   typedef enum int {VARI_ONE, VARI_TWO, VARI_FOUR} vari_form_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   int mismatch_count;
   int results_owed;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int value_items   = 0;
   int quiet_cycles  = 0;

   // Bytes of the value being sent.
   logic [7:0] stream_q[$];

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   rp66_value_decoder_core #(
      .MAX_STRING_BYTES(STRING_LIMIT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   rp66vd_value_checker #(
      .MAX_STRING_BYTES(STRING_LIMIT)
   ) decode_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .fail_count   (mismatch_count),
      .results_owed (results_owed)
   );

   // The receiver stalls at random, as often as the current phase asks.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Give up when neither channel has moved a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("** rp66_value_decoder_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One input transaction, after a random gap with noise on the payload.
   task automatic send_byte(input req_type item);
      req_type noise;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         noise = REQ_BITS'($urandom);
         req_valid   <= 1'b0;
         req_payload <= noise;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Send the first count bytes of stream_q as one value.
   task automatic send_stream(input logic [4:0] code, input int count, input int eod_at);
      req_type item;
      for (int i = 0; i < count; i++) begin
         item.data_byte   = stream_q[i];
         item.start_req   = (i == 0);
         item.rep_code    = (i == 0) ? code : 5'($urandom);
         item.end_of_data = (i == eod_at);
         send_byte(item);
      end
      value_items += count;
   endtask

   task automatic send_strays(input int count);
      req_type item;
      for (int i = 0; i < count; i++) begin
         item           = REQ_BITS'($urandom);
         item.start_req = 1'b0;
         send_byte(item);
      end
   endtask

   // Stop sending until every predicted result has arrived.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   function automatic void push_text(input int count);
      for (int i = 0; i < count; i++) stream_q.push_back(8'($urandom));
   endfunction

   function automatic void push_vari(input vari_form_type form, input logic [29:0] v);
      case (form)
         VARI_ONE: stream_q.push_back({1'b0, v[6:0]});
         VARI_TWO: begin
            stream_q.push_back({2'b10, v[13:8]});
            stream_q.push_back(v[7:0]);
         end
         default: begin
            stream_q.push_back({2'b11, v[29:24]});
            stream_q.push_back(v[23:16]);
            stream_q.push_back(v[15:8]);
            stream_q.push_back(v[7:0]);
         end
      endcase
   endfunction

   // Mostly short lengths, sometimes empty, now and then a long one.
   function automatic int pick_len();
      int roll;
      roll = $urandom_range(0, 39);
      if (roll < 2) return 0;
      if (roll == 2) return $urandom_range(100, 255);
      return $urandom_range(1, 6);
   endfunction

   function automatic void push_obname();
      int n;
      push_vari(vari_form_type'($urandom_range(VARI_ONE, VARI_FOUR)), 30'($urandom));
      push_text(1);
      n = pick_len();
      stream_q.push_back(8'(n));
      push_text(n);
   endfunction

   function automatic void push_ascii();
      int roll;
      int n;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         // Length beyond the limit; the bytes after it are ignored.
         if ($urandom_range(0, 1))
            push_vari(VARI_TWO, 30'($urandom_range(STRING_LIMIT + 1, 16383)));
         else
            push_vari(VARI_FOUR, 30'($urandom_range(STRING_LIMIT + 1, 30'h3FFF_FFFF)));
         push_text(2);
      end else if (roll == 1) begin
         // Length exactly at the limit; only the start of the text follows.
         push_vari(vari_form_type'($urandom_range(VARI_TWO, VARI_FOUR)), 30'(STRING_LIMIT));
         push_text(3);
      end else begin
         n = pick_len();
         if (n < 128)
            push_vari(vari_form_type'($urandom_range(VARI_ONE, VARI_FOUR)), 30'(n));
         else
            push_vari(vari_form_type'($urandom_range(VARI_TWO, VARI_FOUR)), 30'(n));
         push_text(n);
      end
   endfunction

   // Build a well-formed value of the given code in stream_q.
   function automatic void compose(input logic [4:0] code);
      int n;
      stream_q.delete();
      case (code)
         RC_IDENT, RC_UNITS: begin
            n = pick_len();
            stream_q.push_back(8'(n));
            push_text(n);
         end
         RC_ASCII:            push_ascii();
         RC_UVARI, RC_ORIGIN:
            push_vari(vari_form_type'($urandom_range(VARI_ONE, VARI_FOUR)), 30'($urandom));
         RC_OBNAME:           push_obname();
         RC_OBJREF: begin
            n = pick_len();
            stream_q.push_back(8'(n));
            push_text(n);
            push_obname();
         end
         default: begin
            n = int'(fixed_len(code));
            push_text(n == 0 ? 1 : n);
         end
      endcase
   endfunction

   function automatic logic [4:0] pick_code();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? RC_NONE
                                        : 5'($urandom_range(RC_LAST_CODE + 1, CODE_SPACE - 1));
         1, 2, 3: begin
            case ($urandom_range(0, 6))
               0:       return RC_IDENT;
               1:       return RC_ASCII;
               2:       return RC_OBNAME;
               3:       return RC_OBJREF;
               4:       return RC_UNITS;
               5:       return RC_UVARI;
               default: return RC_ORIGIN;
            endcase
         end
         default: return 5'($urandom_range(RC_NONE + 1, RC_LAST_CODE));
      endcase
   endfunction

   // One random value: mostly complete, sometimes cut short by end of data
   // or abandoned for the next start, occasionally followed by stray bytes.
   task automatic random_value(input logic [4:0] code);
      int count;
      int eod_at;
      int roll;
      compose(code);
      count  = stream_q.size();
      eod_at = -1;
      roll   = $urandom_range(0, 9);
      if (roll == 0 && count > 1) begin
         eod_at = $urandom_range(0, count - 2);
         count  = eod_at + 1;
      end else if (roll == 1 && count > 1) begin
         count = $urandom_range(1, count - 1);
      end else if ($urandom_range(0, 3) == 0) begin
         eod_at = count - 1;
      end
      send_stream(code, count, eod_at);
      if ($urandom_range(0, 7) == 0) send_strays($urandom_range(1, 3));
   endtask

   task automatic run_phase(input int sender_idle, input int receiver_stall, input bit sweep);
      int         target;
      int         sweep_code;
      logic [4:0] code;
      send_idle_pct = sender_idle;
      stall_pct     = receiver_stall;
      target        = value_items + PHASE_ITEMS;
      sweep_code    = 0;
      while (value_items < target) begin
         if (sweep && sweep_code < CODE_SPACE) begin
            code = 5'(sweep_code);
            sweep_code++;
         end else begin
            code = pick_code();
         end
         random_value(code);
      end
      wait_for_results();
   endtask

   // Boundary cases of the value formats.
   task automatic run_directed();
      // A byte without a start while idle is dropped.
      send_strays(1);
      stream_q = '{8'h80};
      send_stream(RC_SSHORT, 1, -1);
      stream_q = '{8'h80, 8'h00, 8'h00, 8'h00};
      send_stream(RC_SLONG, 4, -1);
      stream_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_stream(RC_ULONG, 4, -1);
      // Largest four-byte variable-length integer.
      stream_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_stream(RC_UVARI, 4, -1);
      stream_q = '{8'h00};
      send_stream(RC_IDENT, 1, -1);
      // One byte over the string limit; the trailing byte is ignored.
      stream_q = '{8'h90, 8'h01, 8'h41};
      send_stream(RC_ASCII, 3, -1);
      // Exactly at the limit, then abandoned by the next start.
      stream_q = '{8'h90, 8'h00, 8'h42};
      send_stream(RC_ASCII, 3, -1);
      // Empty type goes straight on to the origin; the name is empty too.
      stream_q = '{8'h00, 8'h00, 8'h00, 8'h00};
      send_stream(RC_OBJREF, 4, -1);
      stream_q = '{8'h5A};
      send_stream(RC_ATTREF, 1, -1);
      stream_q = '{8'h00};
      send_stream(RC_NONE, 1, -1);
      // All code bits set: a bad code.
      stream_q = '{8'hFF};
      send_stream(~RC_NONE, 1, -1);
      // A double cut short by end of data after three bytes.
      stream_q = '{8'h3F, 8'hF0, 8'h00};
      send_stream(RC_FDOUBL, 3, 2);
      // Half a value, dropped by the start that follows.
      stream_q = '{8'h12, 8'h34};
      send_stream(RC_SNORM, 1, -1);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_phase(0, 0, 1'b1);
      run_phase(88, 0, 1'b0);
      run_phase(0, 88, 1'b0);
      run_phase(37, 37, 1'b0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("** rp66_value_decoder_core: PASSED **");
      end else begin
         $display("** rp66_value_decoder_core: FAILED **");
      end
      $finish;
   end

endmodule
